// ===== rtl/core/lrbo_pkg.sv =====
// ----------------------------------------------------------------------------
// lrbo_pkg
// shared constants for the landmark range/bearing observer: register map,
// cordic guard bits, arctangent table and the pass-through tag type
// ----------------------------------------------------------------------------
package lrbo_pkg;

    localparam int GUARD_BITS = 8;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CORDIC_W   = DIFF_W + GUARD_BITS + 2;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = DIFF_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int ATAN_LEN   = 24;
    localparam int ANGLE_W    = 32;

    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [2:0] REG_POSE_X       = 3'd0;
    localparam logic [2:0] REG_POSE_Y       = 3'd1;
    localparam logic [2:0] REG_POSE_HEADING = 3'd2;
    localparam logic [2:0] REG_RANGE_LIMIT  = 3'd3;
    localparam logic [2:0] REG_FOV          = 3'd4;

    localparam logic [15:0] FOV_RESET     = 16'd16384;
    localparam logic [15:0] DIST_SAT      = 16'hFFFF;
    localparam logic [31:0] ANGLE_PI      = 32'h8000_0000;

    localparam logic [ANGLE_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [15:0] id;
        logic        last;
    } lrbo_tag_t;

endpackage

// ===== rtl/core/landmark_range_bearing_observer.sv =====
// ----------------------------------------------------------------------------
// landmark_range_bearing_observer
// turns a world-frame landmark into range and bearing seen from the robot
// pose, with a visibility flag against range limit and field of view
// ----------------------------------------------------------------------------
//  channel   ports                                             handshake
//  input     landmark_x, landmark_y, landmark_id, last_landmark  start / busy
//  result    distance, bearing, observed_id, visible, last_of_set result_valid
//  config    paddr, pwdata, prdata                            apb psel/penable
//
//  one word accepted every cycle; busy stays low
//  result is registered through p0, p1, the chain load, the chain, f1 and f2,
//  the chain set by the longer of the cordic chain and the bit-per-stage square root
//  async active-low reset clears all valid bits and loads register defaults
//  the result side cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
module landmark_range_bearing_observer #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [15:0]             landmark_x,
    input  logic signed [15:0]             landmark_y,
    input  logic [15:0]                    landmark_id,
    input  logic                           last_landmark,
    output logic                           result_valid,
    output logic [15:0]                    distance,
    output logic signed [15:0]             bearing,
    output logic [15:0]                    observed_id,
    output logic                           visible,
    output logic                           last_of_set,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lrbo_pkg::PADDR_W-1:0]   paddr,
    input  logic [lrbo_pkg::PDATA_W-1:0]   pwdata,
    output logic [lrbo_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import lrbo_pkg::*;

    localparam int NSTG = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int LAT  = NSTG + 5;
    localparam logic [15:0] RANGE_RESET = 16'(3 << FRAC_BITS);

    // configuration registers
    logic signed [15:0] pose_x_reg;
    logic signed [15:0] pose_y_reg;
    logic [15:0]        pose_heading_reg;
    logic [15:0]        range_limit_reg;
    logic [14:0]        fov_reg;
    logic               cfg_we;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
            range_limit_reg  <= RANGE_RESET;
            fov_reg          <= FOV_RESET[14:0];
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_POSE_X:       pose_x_reg       <= pwdata[15:0];
                REG_POSE_Y:       pose_y_reg       <= pwdata[15:0];
                REG_POSE_HEADING: pose_heading_reg <= pwdata[15:0];
                REG_RANGE_LIMIT:  range_limit_reg  <= pwdata[15:0];
                REG_FOV:          fov_reg          <= pwdata[14:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_POSE_X:       prdata = {16'd0, pose_x_reg};
            REG_POSE_Y:       prdata = {16'd0, pose_y_reg};
            REG_POSE_HEADING: prdata = {16'd0, pose_heading_reg};
            REG_RANGE_LIMIT:  prdata = {16'd0, range_limit_reg};
            REG_FOV:          prdata = {17'd0, fov_reg};
            default:          prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // stage p0: offsets
    logic                     p0_v_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    lrbo_tag_t                p0_tag_reg;
    logic                     accept;

    assign accept = start && !busy;

    // stage p1: squares and half-plane turn
    logic                       p1_v_reg;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg;
    logic [SQ_W-1:0]            sqx_next, sqy_next;
    logic signed [SQ_W-1:0]     dx_wide, dy_wide;
    logic signed [CORDIC_W-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [CORDIC_W-1:0] gx, gy;
    logic [ANGLE_W-1:0]         pz_reg, pz_next;
    logic                       pzero_reg;
    lrbo_tag_t                  p1_tag_reg;

    assign dx_wide  = SQ_W'(dx_reg);
    assign dy_wide  = SQ_W'(dy_reg);
    assign sqx_next = SQ_W'(dx_wide * dx_wide);
    assign sqy_next = SQ_W'(dy_wide * dy_wide);
    assign gx = {{(CORDIC_W - DIFF_W - GUARD_BITS){dx_reg[DIFF_W-1]}}, dx_reg,
                 {GUARD_BITS{1'b0}}};
    assign gy = {{(CORDIC_W - DIFF_W - GUARD_BITS){dy_reg[DIFF_W-1]}}, dy_reg,
                 {GUARD_BITS{1'b0}}};

    always_comb
    begin
        if (dx_reg[DIFF_W-1])
        begin
            px_next = -gx;
            py_next = -gy;
            pz_next = ANGLE_PI;
        end
        else
        begin
            px_next = gx;
            py_next = gy;
            pz_next = '0;
        end
    end

    // iterative chain: index 0 is loaded by stage p2
    logic                       cv_reg   [0:NSTG];
    logic signed [CORDIC_W-1:0] cx_reg   [0:NSTG];
    logic signed [CORDIC_W-1:0] cy_reg   [0:NSTG];
    logic [ANGLE_W-1:0]         cz_reg   [0:NSTG];
    logic [SQ_W-1:0]            rem_reg  [0:NSTG];
    logic [ROOT_W-1:0]          root_reg [0:NSTG];
    logic                       czero_reg[0:NSTG];
    lrbo_tag_t                  ctag_reg [0:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            cv_reg[0] <= 1'b0;
        end
        else
        begin
            p0_v_reg  <= accept;
            p1_v_reg  <= p0_v_reg;
            cv_reg[0] <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg          <= DIFF_W'(landmark_x) - DIFF_W'(pose_x_reg);
        dy_reg          <= DIFF_W'(landmark_y) - DIFF_W'(pose_y_reg);
        p0_tag_reg.id   <= landmark_id;
        p0_tag_reg.last <= last_landmark;
        sqx_reg         <= sqx_next;
        sqy_reg         <= sqy_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        pz_reg          <= pz_next;
        pzero_reg       <= (dx_reg == '0) && (dy_reg == '0);
        p1_tag_reg      <= p0_tag_reg;
        rem_reg[0]      <= sqx_reg + sqy_reg;
        root_reg[0]     <= '0;
        cx_reg[0]       <= px_reg;
        cy_reg[0]       <= py_reg;
        cz_reg[0]       <= pz_reg;
        czero_reg[0]    <= pzero_reg;
        ctag_reg[0]     <= p1_tag_reg;
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        logic signed [CORDIC_W-1:0] cx_next, cy_next;
        logic [ANGLE_W-1:0]         cz_next;
        logic [SQ_W-1:0]            rem_next;
        logic [ROOT_W-1:0]          root_next;

        if (k < CORDIC_STAGES)
        begin : g_rot
            always_comb
            begin
                if (!cy_reg[k][CORDIC_W-1])
                begin
                    cx_next = cx_reg[k] + (cy_reg[k] >>> k);
                    cy_next = cy_reg[k] - (cx_reg[k] >>> k);
                    cz_next = cz_reg[k] + ATAN_TAB[k];
                end
                else
                begin
                    cx_next = cx_reg[k] - (cy_reg[k] >>> k);
                    cy_next = cy_reg[k] + (cx_reg[k] >>> k);
                    cz_next = cz_reg[k] - ATAN_TAB[k];
                end
            end
        end
        else
        begin : g_rot_pass
            assign cx_next = cx_reg[k];
            assign cy_next = cy_reg[k];
            assign cz_next = cz_reg[k];
        end

        if (k < SQRT_STEPS)
        begin : g_sqrt
            localparam int J = SQRT_STEPS - 1 - k;
            logic [SQ_W-1:0] trial;

            assign trial = (SQ_W'(root_reg[k]) << (J + 1)) | (SQ_W'(1) << (2 * J));

            always_comb
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_next  = rem_reg[k] - trial;
                    root_next = root_reg[k] | (ROOT_W'(1) << J);
                end
                else
                begin
                    rem_next  = rem_reg[k];
                    root_next = root_reg[k];
                end
            end
        end
        else
        begin : g_sqrt_pass
            assign rem_next  = rem_reg[k];
            assign root_next = root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[k+1] <= 1'b0;
            end
            else
            begin
                cv_reg[k+1] <= cv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[k+1]    <= cx_next;
            cy_reg[k+1]    <= cy_next;
            cz_reg[k+1]    <= cz_next;
            rem_reg[k+1]   <= rem_next;
            root_reg[k+1]  <= root_next;
            czero_reg[k+1] <= czero_reg[NSTG - NSTG + k];
            ctag_reg[k+1]  <= ctag_reg[k];
        end
    end

    // stage f1: round, saturate, reference to heading
    logic              f1_v_reg;
    logic [15:0]       f1_dist_reg, f1_dist_next;
    logic [15:0]       f1_brg_reg, f1_brg_next;
    lrbo_tag_t         f1_tag_reg;
    logic [ROOT_W-1:0] root_rnd;
    logic [ANGLE_W-1:0] z_fin;
    logic [15:0]       ang16;

    assign root_rnd = root_reg[NSTG] + ROOT_W'(rem_reg[NSTG] > SQ_W'(root_reg[NSTG]));
    assign f1_dist_next = root_rnd[ROOT_W-1] ? DIST_SAT : root_rnd[15:0];
    assign z_fin = czero_reg[NSTG] ? '0 : cz_reg[NSTG];
    assign ang16 = z_fin[31:16] + 16'(z_fin[15]);
    assign f1_brg_next = ang16 - pose_heading_reg;

    // stage f2: visibility
    logic        out_v_reg;
    logic [15:0] distance_reg;
    logic [15:0] bearing_reg;
    logic        visible_reg, visible_next;
    lrbo_tag_t   out_tag_reg;
    logic [16:0] brg_mag;

    assign brg_mag = f1_brg_reg[15] ? (17'd0 - {1'b1, f1_brg_reg}) : {1'b0, f1_brg_reg};
    assign visible_next = (f1_dist_reg < range_limit_reg)
                       && ({brg_mag, 1'b0} < {3'd0, fov_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg  <= cv_reg[NSTG];
            out_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_dist_reg  <= f1_dist_next;
        f1_brg_reg   <= f1_brg_next;
        f1_tag_reg   <= ctag_reg[NSTG];
        distance_reg <= f1_dist_reg;
        bearing_reg  <= f1_brg_reg;
        visible_reg  <= visible_next;
        out_tag_reg  <= f1_tag_reg;
    end

    assign result_valid = out_v_reg;
    assign distance     = distance_reg;
    assign bearing      = bearing_reg;
    assign observed_id  = out_tag_reg.id;
    assign visible      = visible_reg;
    assign last_of_set  = out_tag_reg.last;

`ifndef NO_ASSERTIONS
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT result_valid)
        else $error("accepted word did not come out on time");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, LAT))
        else $error("result without a matching accepted word");

    a_vis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && visible |-> distance != DIST_SAT)
        else $error("saturated distance flagged visible");

    a_vis_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && visible |-> bearing != 16'h8000)
        else $error("bearing of pi flagged visible");
`endif

endmodule

// ===== tb/tb_landmark_range_bearing_observer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_landmark_range_bearing_observer
// drives landmark words into the observer at random burst rates, rewrites the
// pose and visibility registers over the apb port between phases, and checks
// every distance, bearing, id, visible and last flag against a bit-exact
// square-root and vectoring-cordic model kept in the bench
// ----------------------------------------------------------------------------
module tb_landmark_range_bearing_observer;

    import lrbo_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = (CORDIC_STAGES > 17 ? CORDIC_STAGES : 17) + 5;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_WORDS   = 88;
    localparam int REPORT_MAX    = 10;

    localparam logic [31:0] ARCTAN_STEP [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [15:0] range_q;
        logic [15:0] brg;
        logic [15:0] id;
        logic        vis;
        logic        last;
    } sighting_t;

    typedef enum logic {ROW_LANDMARK, ROW_REGISTER} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [2:0]  idx;
        logic [31:0] value;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] id;
        logic        last;
        logic        typed;
        sighting_t   want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] landmark_x;
    logic signed [15:0] landmark_y;
    logic [15:0]        landmark_id;
    logic               last_landmark;
    logic               result_valid;
    logic [15:0]        distance;
    logic signed [15:0] bearing;
    logic [15:0]        observed_id;
    logic               visible;
    logic               last_of_set;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // shadow of the register file
    logic signed [15:0] cfg_pose_x;
    logic signed [15:0] cfg_pose_y;
    logic [15:0]        cfg_heading;
    logic [15:0]        cfg_range;
    logic [14:0]        cfg_fov;

    sighting_t pending_sightings [$];
    plan_row_t directed_plan [$];

    int faults;
    int shown;
    int words_sent;
    int words_seen;
    int seen_visible;
    int seen_saturated;
    int settings_used;

    sighting_t got;
    sighting_t want;
    string     bad_fields;

    landmark_range_bearing_observer #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (8)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .landmark_x    (landmark_x),
        .landmark_y    (landmark_y),
        .landmark_id   (landmark_id),
        .last_landmark (last_landmark),
        .result_valid  (result_valid),
        .distance      (distance),
        .bearing       (bearing),
        .observed_id   (observed_id),
        .visible       (visible),
        .last_of_set   (last_of_set),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    function automatic longint unsigned round_sqrt(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s > r)
            r = r + 1;
        return r;
    endfunction

    function automatic logic [31:0] vector_angle(input longint x, input longint y);
        logic [31:0] z;
        longint      xs;
        longint      ys;
        z = '0;
        if (x == 0 && y == 0)
            return '0;
        x = x * 256;
        y = y * 256;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic sighting_t observe_landmark(input logic [15:0] lx, input logic [15:0] ly,
                                                   input logic [15:0] lid, input logic llast);
        sighting_t       s;
        longint          dx;
        longint          dy;
        longint unsigned root;
        logic [31:0]     z;
        logic [15:0]     brg;
        int              mag;
        dx = longint'($signed(lx)) - longint'(cfg_pose_x);
        dy = longint'($signed(ly)) - longint'(cfg_pose_y);
        root = round_sqrt(longint'(dx * dx + dy * dy));
        if (root > 65535)
            root = 65535;
        z = vector_angle(dx, dy) + 32'h0000_8000;
        brg = z[31:16] - cfg_heading;
        mag = brg[15] ? 65536 - int'(brg) : int'(brg);
        s.range_q = root[15:0];
        s.brg     = brg;
        s.id      = lid;
        s.vis     = (root < longint'(cfg_range)) && (2 * mag < int'(cfg_fov));
        s.last    = llast;
        return s;
    endfunction

    // one result per accepted word, checked in order
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            got = '{distance, bearing, observed_id, visible, last_of_set};
            words_seen++;
            if (visible === 1'b1)
                seen_visible++;
            if (distance === DIST_SAT)
                seen_saturated++;
            if (pending_sightings.size() == 0)
            begin
                faults++;
                if (shown < REPORT_MAX)
                begin
                    shown++;
                    $display("result with nothing outstanding: dist=%0d brg=%0d id=%h vis=%b last=%b",
                             got.range_q, $signed(got.brg), got.id, got.vis, got.last);
                end
            end
            else
            begin
                want = pending_sightings.pop_front();
                bad_fields = "";
                if (got.range_q !== want.range_q) bad_fields = {bad_fields, " distance"};
                if (got.brg  !== want.brg)  bad_fields = {bad_fields, " bearing"};
                if (got.id   !== want.id)   bad_fields = {bad_fields, " observed_id"};
                if (got.vis  !== want.vis)  bad_fields = {bad_fields, " visible"};
                if (got.last !== want.last) bad_fields = {bad_fields, " last_of_set"};
                if (bad_fields != "")
                begin
                    faults++;
                    if (shown < REPORT_MAX)
                    begin
                        shown++;
                        $display("mismatch on result %0d (%s ): exp dist=%0d brg=%0d id=%h vis=%b last=%b",
                                 words_seen, bad_fields, want.range_q, $signed(want.brg), want.id,
                                 want.vis, want.last);
                        $display("    got dist=%0d brg=%0d id=%h vis=%b last=%b",
                                 got.range_q, $signed(got.brg), got.id, got.vis, got.last);
                    end
                end
            end
        end
    end

    task automatic idle(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_sightings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_POSE_X:       cfg_pose_x  = value[15:0];
            REG_POSE_Y:       cfg_pose_y  = value[15:0];
            REG_POSE_HEADING: cfg_heading = value[15:0];
            REG_RANGE_LIMIT:  cfg_range   = value[15:0];
            REG_FOV:          cfg_fov     = value[14:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_landmark(input logic [15:0] lx, input logic [15:0] ly,
                                 input logic [15:0] lid, input logic llast,
                                 input logic typed, input sighting_t known);
        @(negedge clk);
        start         <= 1'b1;
        landmark_x    <= lx;
        landmark_y    <= ly;
        landmark_id   <= lid;
        last_landmark <= llast;
        do @(posedge clk); while (busy !== 1'b0);
        pending_sightings.insert(pending_sightings.size(),
                                 typed ? known : observe_landmark(lx, ly, lid, llast));
        words_sent++;
    endtask

    function automatic void plan_landmark(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] id, input logic last);
        plan_row_t r;
        r = '0;
        r.kind = ROW_LANDMARK;
        r.x = x;
        r.y = y;
        r.id = id;
        r.last = last;
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    // landmark whose whole result is obvious from the registers
    function automatic void plan_known(input logic [15:0] x, input logic [15:0] y,
                                       input logic [15:0] id, input logic last,
                                       input logic [15:0] range_q, input logic [15:0] brg,
                                       input logic vis);
        plan_row_t r;
        r = '0;
        r.kind = ROW_LANDMARK;
        r.x = x;
        r.y = y;
        r.id = id;
        r.last = last;
        r.typed = 1'b1;
        r.want = '{range_q, brg, id, vis, last};
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    function automatic void plan_reg(input logic [2:0] idx, input logic [31:0] value);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REGISTER;
        r.idx = idx;
        r.value = value;
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    function automatic logic [15:0] near_value(input logic [15:0] centre, input int span);
        int v;
        v = int'($signed(centre)) + int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_pose();
        case ($urandom_range(0, 8))
            6:       return pick_extreme();
            7, 8:    return near_value(16'h0000, 2048);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic write_random_setting();
        logic [15:0] lim;
        logic [14:0] fov;
        case ($urandom_range(0, 5))
            0:       lim = 16'h0000;
            1:       lim = 16'hFFFF;
            default: lim = 16'($urandom_range(128, 4096));
        endcase
        case ($urandom_range(0, 5))
            0:       fov = 15'h0000;
            1:       fov = 15'h7FFF;
            default: fov = 15'($urandom());
        endcase
        write_reg(REG_POSE_X, {16'($urandom()), pick_pose()});
        write_reg(REG_POSE_Y, {16'($urandom()), pick_pose()});
        write_reg(REG_POSE_HEADING,
                  {16'($urandom()), ($urandom_range(0, 4) == 0) ? pick_extreme() : 16'($urandom())});
        write_reg(REG_RANGE_LIMIT, {16'($urandom()), lim});
        write_reg(REG_FOV, {17'($urandom()), fov});
        settings_used++;
    endtask

    task automatic send_random_landmark();
        logic [15:0] lx;
        logic [15:0] ly;
        int          span;
        span = (cfg_range < 64) ? 512 : (cfg_range > 6000 ? 6000 : int'(cfg_range));
        case ($urandom_range(0, 9))
            7:
            begin
                lx = cfg_pose_x;
                ly = cfg_pose_y;
            end
            8:
            begin
                lx = 16'($urandom());
                ly = 16'($urandom());
            end
            9:
            begin
                lx = pick_extreme();
                ly = pick_extreme();
            end
            default:
            begin
                lx = near_value(cfg_pose_x, span);
                ly = near_value(cfg_pose_y, span);
            end
        endcase
        send_landmark(lx, ly, 16'($urandom()), $urandom_range(0, 7) == 0, 1'b0, '0);
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_landmark_range_bearing_observer: FAIL");
        $finish;
    end

    initial
    begin
        int burst;
        int spare;
        bit steady;

        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        landmark_x    = '0;
        landmark_y    = '0;
        landmark_id   = '0;
        last_landmark = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_pose_x    = '0;
        cfg_pose_y    = '0;
        cfg_heading   = '0;
        cfg_range     = 16'd768;
        cfg_fov       = FOV_RESET[14:0];
        faults        = 0;
        shown         = 0;
        words_sent    = 0;
        words_seen    = 0;
        seen_visible  = 0;
        seen_saturated = 0;
        settings_used = 1;

        // reset defaults: pose at origin, heading 0, 3 m range, quarter-turn view
        plan_known(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0, 16'h0000, 1'b1);
        plan_landmark(16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
        plan_landmark(16'h8000, 16'h0000, 16'h8000, 1'b0);
        plan_landmark(16'h0000, 16'h7FFF, 16'h5A5A, 1'b0);
        plan_landmark(16'h0000, 16'h8000, 16'hA5A5, 1'b1);
        plan_landmark(16'd100, 16'd50, 16'h0001, 1'b0);
        plan_landmark(16'hFF00, 16'hFFC0, 16'h0002, 1'b1);
        // robot in the far corner, landmark in the opposite one saturates
        plan_reg(REG_POSE_X, 32'h0000_8000);
        plan_reg(REG_POSE_Y, 32'h0000_8000);
        plan_landmark(16'h7FFF, 16'h7FFF, 16'h0003, 1'b0);
        plan_known(16'h8000, 16'h8000, 16'h0004, 1'b1, 16'd0, 16'h0000, 1'b1);
        // heading of pi puts a landmark on the robot at bearing -pi
        plan_reg(REG_POSE_HEADING, 32'h0000_8000);
        plan_known(16'h8000, 16'h8000, 16'h0005, 1'b0, 16'd0, 16'h8000, 1'b0);
        plan_reg(REG_POSE_X, 32'hFFFF_7FFF);
        plan_reg(REG_POSE_Y, 32'h1234_7FFF);
        plan_landmark(16'h8000, 16'h8000, 16'h0006, 1'b0);
        plan_known(16'h7FFF, 16'h7FFF, 16'h0007, 1'b1, 16'd0, 16'h8000, 1'b0);
        // zero range limit hides everything
        plan_reg(REG_POSE_HEADING, 32'h0000_4000);
        plan_reg(REG_RANGE_LIMIT, 32'h0000_0000);
        plan_known(16'h7FFF, 16'h7FFF, 16'h0008, 1'b0, 16'd0, 16'hC000, 1'b0);
        // zero field of view hides everything
        plan_reg(REG_RANGE_LIMIT, 32'hFFFF_FFFF);
        plan_reg(REG_FOV, 32'h0000_0000);
        plan_known(16'h7FFF, 16'h7FFF, 16'h0009, 1'b0, 16'd0, 16'hC000, 1'b0);
        plan_reg(REG_FOV, 32'hFFFF_FFFF);
        plan_reg(REG_POSE_HEADING, 32'hFFFF_0000);
        plan_known(16'h7FFF, 16'h7FFF, 16'h000A, 1'b1, 16'd0, 16'h0000, 1'b1);
        plan_landmark(16'h7FFF, 16'h7D00, 16'h000B, 1'b0);
        // writes past the register map must change nothing
        for (int i = int'(REG_FOV) + 1; i < (1 << (PADDR_W - 2)); i++)
            plan_reg(3'(i), 32'hFFFF_FFFF);
        plan_known(16'h7FFF, 16'h7FFF, 16'h000C, 1'b1, 16'd0, 16'h0000, 1'b1);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_REGISTER)
            begin
                idle(1);
                wait_drained();
                write_reg(directed_plan[i].idx, directed_plan[i].value);
                settings_used++;
            end
            else
            begin
                idle($urandom_range(0, 3));
                send_landmark(directed_plan[i].x, directed_plan[i].y, directed_plan[i].id,
                              directed_plan[i].last, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            idle(1);
            wait_drained();
            write_random_setting();
            steady = (phase % 3 == 0);
            burst = $urandom_range(1, 24);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // hold the sender until the pipeline has emptied
                if (phase % 4 == 1 && k == PHASE_WORDS / 2)
                begin
                    idle(1);
                    wait_drained();
                end
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 24);
                    if (!steady)
                        idle($urandom_range(1, 9));
                end
                burst--;
                send_random_landmark();
            end
        end

        idle(1);
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);

        spare = pending_sightings.size();
        $display("sent %0d landmark words under %0d register settings; %0d results back",
                 words_sent, settings_used, words_seen);
        $display("%0d reported visible, %0d with saturated range, %0d faults",
                 seen_visible, seen_saturated, faults + spare);
        if (faults == 0 && spare == 0)
            $display("tb_landmark_range_bearing_observer: PASS");
        else
            $display("tb_landmark_range_bearing_observer: FAIL");
        $finish;
    end

endmodule
